// File: hdl/tar_record_stream_parser_macros.svh
// Assertion macros for the tar record stream parser.
`ifndef TAR_RECORD_STREAM_PARSER_MACROS_SVH
`define TAR_RECORD_STREAM_PARSER_MACROS_SVH

// Clocked check with an explicit clock and reset.
`define TRS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check on clk_i, disabled while rst_ni is low.
`define TRS_ASSERT(lbl, prop, msg) \
  `TRS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: hdl/trs_pkg.sv
package trs_pkg;

  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned OFF_W      = 9;
  localparam int unsigned NUM_FIELDS = 7;
  localparam int unsigned FIDX_W     = $clog2(NUM_FIELDS);
  localparam int unsigned SIZE_FIELD = 3;
  localparam int unsigned MODE_FIELD = 0;
  localparam int unsigned UID_FIELD  = 1;
  localparam int unsigned GID_FIELD  = 2;
  localparam int unsigned MTIM_FIELD = 4;
  localparam int unsigned DMAJ_FIELD = 5;
  localparam int unsigned DMIN_FIELD = 6;

  localparam logic [OFF_W-1:0] REC_LAST = 9'd511;
  localparam logic [OFF_W-1:0] TYPE_OFF = 9'd156;

  localparam logic [OFF_W-1:0] FLD_FIRST [NUM_FIELDS] =
    '{9'd100, 9'd108, 9'd116, 9'd124, 9'd136, 9'd329, 9'd337};
  localparam logic [OFF_W-1:0] FLD_LAST [NUM_FIELDS] =
    '{9'd107, 9'd115, 9'd123, 9'd135, 9'd147, 9'd336, 9'd344};

  localparam int unsigned MAGIC_LEN = 5;
  localparam int unsigned MIDX_W    = $clog2(MAGIC_LEN);
  localparam logic [OFF_W-1:0] MAGIC_FIRST = 9'd257;
  localparam logic [OFF_W-1:0] MAGIC_LAST  = 9'd261;
  localparam logic [7:0] MAGIC_TEXT [MAGIC_LEN] = '{8'h75, 8'h73, 8'h74, 8'h61, 8'h72};

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_SEVEN = 8'h37;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_END    = 2'd2,
    KIND_ERROR  = 2'd3
  } out_kind_e;

  localparam logic ERR_FORMAT = 1'b0;
  localparam logic ERR_TRUNC  = 1'b1;

  localparam logic [2:0] TYPE_REGULAR = 3'd0;

  typedef struct packed {
    logic [11:0]        perm;
    logic [FIELD_W-1:0] uid;
    logic [FIELD_W-1:0] gid;
    logic [FIELD_W-1:0] size;
    logic [FIELD_W-1:0] mtime;
    logic [FIELD_W-1:0] dev_major;
    logic [FIELD_W-1:0] dev_minor;
    logic [2:0]         type_code;
    logic               typed;
    logic               bad;
    logic               empty;
  } hdr_t;

endpackage

// File: hdl/trs_hdr_decode.sv
module trs_hdr_decode (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      byte_en_i,
  input  logic [trs_pkg::OFF_W-1:0] offset_i,
  input  logic [7:0]                byte_i,
  output trs_pkg::hdr_t             hdr_o
);
  import trs_pkg::*;

  logic [FIELD_W-1:0] fields_q [NUM_FIELDS];
  logic [FIELD_W-1:0] acc_q, acc_d, acc_base;
  logic               trailer_q, trailer_d, trailer_base;
  logic               ferr_q, ferr_d;
  logic               magic_ok_q, magic_ok_d;
  logic               empty_q, empty_d;
  logic [2:0]         type_q, type_d;
  logic               typed_q, typed_d;
  logic               hit, is_first, is_last, digit;
  logic [FIDX_W-1:0]  idx;
  logic [MIDX_W-1:0]  midx;

  always_comb begin
    hit      = 1'b0;
    idx      = '0;
    is_first = 1'b0;
    is_last  = 1'b0;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      if (offset_i >= FLD_FIRST[i] && offset_i <= FLD_LAST[i]) begin
        hit      = 1'b1;
        idx      = FIDX_W'(i);
        is_first = (offset_i == FLD_FIRST[i]);
        is_last  = (offset_i == FLD_LAST[i]);
      end
    end
  end

  assign midx         = MIDX_W'(offset_i - MAGIC_FIRST);
  assign acc_base     = is_first ? '0 : acc_q;
  assign trailer_base = is_first ? 1'b0 : trailer_q;
  assign digit        = !trailer_base && byte_i >= CH_ZERO && byte_i <= CH_SEVEN;

  always_comb begin
    acc_d      = acc_q;
    trailer_d  = trailer_q;
    ferr_d     = ferr_q;
    magic_ok_d = magic_ok_q;
    empty_d    = empty_q;
    type_d     = type_q;
    typed_d    = typed_q;
    if (offset_i == '0) begin
      empty_d    = (byte_i == CH_NUL);
      magic_ok_d = 1'b1;
      ferr_d     = 1'b0;
    end
    if (offset_i == TYPE_OFF) begin
      if (byte_i == CH_ZERO || byte_i == CH_SEVEN) begin
        type_d  = TYPE_REGULAR;
        typed_d = 1'b1;
      end else if (byte_i >= CH_ONE && byte_i <= CH_SIX) begin
        type_d  = byte_i[2:0];
        typed_d = 1'b1;
      end else begin
        type_d  = TYPE_REGULAR;
        typed_d = 1'b0;
      end
    end
    if (offset_i >= MAGIC_FIRST && offset_i <= MAGIC_LAST && byte_i != MAGIC_TEXT[midx]) begin
      magic_ok_d = 1'b0;
    end
    if (hit) begin
      if (digit) begin
        acc_d     = {acc_base[FIELD_W-4:0], byte_i[2:0]};
        trailer_d = trailer_base;
      end else begin
        acc_d     = acc_base;
        trailer_d = 1'b1;
        if (byte_i != CH_NUL && byte_i != CH_SPACE) begin
          ferr_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      trailer_q  <= 1'b0;
      ferr_q     <= 1'b0;
      magic_ok_q <= 1'b1;
      empty_q    <= 1'b0;
      type_q     <= TYPE_REGULAR;
      typed_q    <= 1'b0;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        fields_q[i] <= '0;
      end
    end else if (byte_en_i) begin
      acc_q      <= acc_d;
      trailer_q  <= trailer_d;
      ferr_q     <= ferr_d;
      magic_ok_q <= magic_ok_d;
      empty_q    <= empty_d;
      type_q     <= type_d;
      typed_q    <= typed_d;
      if (hit && is_last) begin
        fields_q[idx] <= acc_d;
      end
    end
  end

  assign hdr_o.perm      = fields_q[MODE_FIELD][11:0];
  assign hdr_o.uid       = fields_q[UID_FIELD];
  assign hdr_o.gid       = fields_q[GID_FIELD];
  assign hdr_o.size      = fields_q[SIZE_FIELD];
  assign hdr_o.mtime     = fields_q[MTIM_FIELD];
  assign hdr_o.dev_major = fields_q[DMAJ_FIELD];
  assign hdr_o.dev_minor = fields_q[DMIN_FIELD];
  assign hdr_o.type_code = type_q;
  assign hdr_o.typed     = typed_q;
  assign hdr_o.bad       = !magic_ok_q || ferr_q;
  assign hdr_o.empty     = empty_q;

endmodule

// File: hdl/tar_record_stream_parser.sv
// Channel  Direction  Handshake               Payload
// in       sink       in_valid_i / in_stall_o   req_type_i, data_byte_i
// out      source     out_valid_o / out_stall_i out_kind_o .. error_code_o
//
// One request is taken per cycle while in_stall_o is low; its result, if any, is in
// the output register on the next cycle.
// Rate is one byte per cycle while not stalled, set by the single pass from the
// accepted byte to the output register; header fields decode one digit per byte.
// rst_ni clears all control state asynchronously; no clearing pass is needed.
// in_stall_o is high only while a held result is stalled downstream.
`include "tar_record_stream_parser_macros.svh"

module tar_record_stream_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_kind_o,
  output logic [2:0]  entry_type_o,
  output logic [11:0] perm_bits_o,
  output logic [31:0] owner_id_o,
  output logic [31:0] group_id_o,
  output logic [31:0] file_size_o,
  output logic [31:0] mod_time_o,
  output logic [31:0] device_major_o,
  output logic [31:0] device_minor_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_payload_o,
  output logic        error_code_o
);
  import trs_pkg::*;

  typedef enum logic [5:0] {
    PH_HEADER   = 6'b000001,
    PH_DATA     = 6'b000010,
    PH_SKIPDATA = 6'b000100,
    PH_PAD      = 6'b001000,
    PH_TRAILER  = 6'b010000,
    PH_DONE     = 6'b100000
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [OFF_W-1:0]   off_q, off_d;
  logic               empty_seen_q, empty_seen_d;
  logic [FIELD_W-1:0] left_q, left_d;
  logic [OFF_W-1:0]   pad_q, pad_d;
  logic               in_acc, hdr_en, res_v;
  hdr_t               hdr;

  logic        out_valid_q;
  out_kind_e   kind_q, kind_d;
  logic [2:0]  etype_q, etype_d;
  logic [11:0] perm_q, perm_d;
  logic [31:0] uid_q, uid_d, gid_q, gid_d, size_q, size_d, mtime_q, mtime_d;
  logic [31:0] dmaj_q, dmaj_d, dmin_q, dmin_d;
  logic [7:0]  pbyte_q, pbyte_d;
  logic        last_q, last_d;
  logic        err_q, err_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  trs_hdr_decode u_hdr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_en_i (hdr_en),
    .offset_i  (off_q),
    .byte_i    (data_byte_i),
    .hdr_o     (hdr)
  );

  always_comb begin
    phase_d      = phase_q;
    off_d        = off_q;
    empty_seen_d = empty_seen_q;
    left_d       = left_q;
    pad_d        = pad_q;
    hdr_en       = 1'b0;
    res_v        = 1'b0;
    kind_d       = KIND_HEADER;
    etype_d      = '0;
    perm_d       = '0;
    uid_d        = '0;
    gid_d        = '0;
    size_d       = '0;
    mtime_d      = '0;
    dmaj_d       = '0;
    dmin_d       = '0;
    pbyte_d      = '0;
    last_d       = 1'b0;
    err_d        = ERR_FORMAT;
    if (in_acc && phase_q != PH_DONE) begin
      if (req_type_i) begin
        res_v   = 1'b1;
        phase_d = PH_DONE;
        if ((phase_q == PH_HEADER || phase_q == PH_TRAILER) && off_q == '0) begin
          kind_d = KIND_END;
        end else begin
          kind_d = KIND_ERROR;
          err_d  = ERR_TRUNC;
        end
      end else begin
        unique case (phase_q) inside
          PH_HEADER: begin
            hdr_en = 1'b1;
            if (off_q == REC_LAST) begin
              off_d = '0;
              if (hdr.empty) begin
                if (empty_seen_q) begin
                  phase_d = PH_TRAILER;
                end else begin
                  empty_seen_d = 1'b1;
                end
              end else if (hdr.bad) begin
                res_v   = 1'b1;
                kind_d  = KIND_ERROR;
                err_d   = ERR_FORMAT;
                phase_d = PH_DONE;
              end else begin
                left_d = hdr.size;
                pad_d  = OFF_W'(~hdr.size[OFF_W-1:0]) + OFF_W'(1);
                if (hdr.size == '0) begin
                  phase_d = PH_HEADER;
                end else begin
                  phase_d = hdr.typed ? PH_DATA : PH_SKIPDATA;
                end
                if (hdr.typed) begin
                  res_v   = 1'b1;
                  kind_d  = KIND_HEADER;
                  etype_d = hdr.type_code;
                  perm_d  = hdr.perm;
                  uid_d   = hdr.uid[31:0];
                  gid_d   = hdr.gid[31:0];
                  size_d  = hdr.size[31:0];
                  mtime_d = hdr.mtime[31:0];
                  dmaj_d  = hdr.dev_major[31:0];
                  dmin_d  = hdr.dev_minor[31:0];
                end
              end
            end else begin
              off_d = off_q + OFF_W'(1);
            end
          end
          PH_DATA, PH_SKIPDATA: begin
            left_d = left_q - FIELD_W'(1);
            if (phase_q == PH_DATA) begin
              res_v   = 1'b1;
              kind_d  = KIND_DATA;
              etype_d = hdr.type_code;
              pbyte_d = data_byte_i;
              last_d  = (left_q == FIELD_W'(1));
            end
            if (left_q == FIELD_W'(1)) begin
              phase_d = (pad_q != '0) ? PH_PAD : PH_HEADER;
            end
          end
          PH_PAD: begin
            pad_d = pad_q - OFF_W'(1);
            if (pad_q == OFF_W'(1)) begin
              phase_d = PH_HEADER;
            end
          end
          PH_TRAILER: begin
            if (off_q == '0 && data_byte_i != CH_NUL) begin
              res_v   = 1'b1;
              kind_d  = KIND_ERROR;
              err_d   = ERR_TRUNC;
              phase_d = PH_DONE;
            end else begin
              off_d = off_q + OFF_W'(1);
            end
          end
          default: phase_d = PH_DONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      off_q        <= '0;
      empty_seen_q <= 1'b0;
      left_q       <= '0;
      pad_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      off_q        <= off_d;
      empty_seen_q <= empty_seen_d;
      left_q       <= left_d;
      pad_q        <= pad_d;
      if (in_acc) begin
        out_valid_q <= res_v;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && res_v) begin
      kind_q  <= kind_d;
      etype_q <= etype_d;
      perm_q  <= perm_d;
      uid_q   <= uid_d;
      gid_q   <= gid_d;
      size_q  <= size_d;
      mtime_q <= mtime_d;
      dmaj_q  <= dmaj_d;
      dmin_q  <= dmin_d;
      pbyte_q <= pbyte_d;
      last_q  <= last_d;
      err_q   <= err_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = kind_q;
  assign entry_type_o   = etype_q;
  assign perm_bits_o    = perm_q;
  assign owner_id_o     = uid_q;
  assign group_id_o     = gid_q;
  assign file_size_o    = size_q;
  assign mod_time_o     = mtime_q;
  assign device_major_o = dmaj_q;
  assign device_minor_o = dmin_q;
  assign payload_byte_o = pbyte_q;
  assign last_payload_o = last_q;
  assign error_code_o   = err_q;

  `TRS_ASSERT(a_done_silent, (in_acc && phase_q == PH_DONE) |=> !out_valid_q, "result after end")
  `TRS_ASSERT(a_last_leaves_data, (out_valid_q && kind_q == KIND_DATA && last_q) |-> (phase_q == PH_PAD || phase_q == PH_HEADER), "last byte left data phase open")
  `TRS_ASSERT(a_pad_nonzero, (phase_q == PH_PAD) |-> (pad_q != '0), "pad phase with no padding")
  `TRS_ASSERT(a_data_nonzero, (phase_q == PH_DATA || phase_q == PH_SKIPDATA) |-> (left_q != '0 && off_q == '0), "data phase with no data left")

endmodule
